FILE: sv/crsf_pkg.sv
// crsf_pkg: shared constants, types and helper functions of the crsf frame parser
// no dependencies; used by every module of the parser

package crsf_pkg;

	// payload store and result sizes
	localparam int PAYLOAD_BYTES = 22;
	localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
	localparam int STORE_IDX_W   = $clog2(PAYLOAD_BYTES);
	localparam int CHAN_COUNT    = 16;
	localparam int CHAN_BITS     = 11;
	localparam int VALUE_BITS    = CHAN_COUNT * CHAN_BITS;
	localparam int SLOT_BITS     = 4 * CHAN_BITS;

	// frame queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// crc-8, msb first, init zero
	localparam logic [7:0] CRC_POLY = 8'hD5;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_RC     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_LS     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_LS_TX  = 2'd3;

	// configuration reset values
	localparam logic [7:0] SYNC_RESET       = 8'd200;
	localparam logic [7:0] TYPE_RC_RESET    = 8'd22;
	localparam logic [7:0] TYPE_LS_RESET    = 8'd20;
	localparam logic [7:0] TYPE_LS_TX_RESET = 8'd29;

	// payload length of each supported frame kind
	localparam logic [4:0] PLEN_RC    = 5'd22;
	localparam logic [4:0] PLEN_LS    = 5'd10;
	localparam logic [4:0] PLEN_LS_TX = 5'd6;

	typedef enum logic [1:0] {
		KIND_RC    = 2'd0,
		KIND_LS    = 2'd1,
		KIND_LS_TX = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// one frame outcome handed from front to back
	typedef struct packed {
		logic                    ok;
		kind_t                   kind;
		logic [PAYLOAD_BITS-1:0] payload;
	} frame_rec_t;

	function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic logic [4:0] payload_len(kind_t k);
		logic [4:0] n;
		case (k)
			KIND_RC: n = PLEN_RC;
			KIND_LS: n = PLEN_LS;
			default: n = PLEN_LS_TX;
		endcase
		return n;
	endfunction

endpackage

FILE: sv/crsf_front.sv
// crsf_front: byte-level frame state machine, crc check, payload store, config registers
// depends on crsf_pkg; emits one frame_rec_t per buffer outcome

module crsf_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic                             q_full,
	input  logic [7:0]                       data_byte,
	input  logic                             buffer_end,
	input  logic                             cfg_we,
	input  logic [crsf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_data,
	output logic                             rec_push,
	output crsf_pkg::frame_rec_t             rec
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_TYPE,
		PH_SKIP,
		PH_PAYLOAD,
		PH_CRC,
		PH_DONE
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [7:0]          len_q, len_d;
	logic [7:0]          cnt_q, cnt_d;
	logic [7:0]          crc_q, crc_d;
	crsf_pkg::kind_t     kind_q, kind_d;
	crsf_pkg::kind_t     kind_b;
	logic                accept;
	logic                outcome;
	logic                ok;
	logic                store_we;
	logic [7:0]          sync_q, type_rc_q, type_ls_q, type_ls_tx_q;
	logic [7:0]          store_q [crsf_pkg::PAYLOAD_BYTES];

	assign accept = push && !q_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q       <= crsf_pkg::SYNC_RESET;
			type_rc_q    <= crsf_pkg::TYPE_RC_RESET;
			type_ls_q    <= crsf_pkg::TYPE_LS_RESET;
			type_ls_tx_q <= crsf_pkg::TYPE_LS_TX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				crsf_pkg::REG_SYNC:       sync_q       <= cfg_data;
				crsf_pkg::REG_TYPE_RC:    type_rc_q    <= cfg_data;
				crsf_pkg::REG_TYPE_LS:    type_ls_q    <= cfg_data;
				crsf_pkg::REG_TYPE_LS_TX: type_ls_tx_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// type classification, rc channels has priority over the statistics types
	always_comb begin
		if (data_byte == type_rc_q)
			kind_b = crsf_pkg::KIND_RC;
		else if (data_byte == type_ls_q)
			kind_b = crsf_pkg::KIND_LS;
		else if (data_byte == type_ls_tx_q)
			kind_b = crsf_pkg::KIND_LS_TX;
		else
			kind_b = crsf_pkg::KIND_NONE;
	end

	// next-state logic of the frame machine
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		crc_d    = crc_q;
		kind_d   = kind_q;
		outcome  = 1'b0;
		ok       = 1'b0;
		store_we = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_HUNT: begin
					if (data_byte == sync_q) phase_d = PH_LEN;
				end
				PH_LEN: begin
					len_d   = data_byte;
					phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					if (kind_b != crsf_pkg::KIND_NONE) begin
						if (len_q != {3'b000, crsf_pkg::payload_len(kind_b)} + 8'd2) begin
							outcome = 1'b1;
						end else begin
							kind_d  = kind_b;
							crc_d   = crsf_pkg::crc8_update(8'h00, data_byte);
							cnt_d   = 8'd0;
							phase_d = PH_PAYLOAD;
						end
					end else if (len_q == 8'd0) begin
						// zero length: the type byte may itself be a sync byte
						phase_d = (data_byte == sync_q) ? PH_LEN : PH_HUNT;
					end else if (len_q == 8'd1) begin
						phase_d = PH_HUNT;
					end else begin
						cnt_d   = len_q - 8'd1;
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					cnt_d = cnt_q - 8'd1;
					if (cnt_d == 8'd0) phase_d = PH_HUNT;
				end
				PH_PAYLOAD: begin
					store_we = 1'b1;
					crc_d    = crsf_pkg::crc8_update(crc_q, data_byte);
					cnt_d    = cnt_q + 8'd1;
					if (cnt_d >= {3'b000, crsf_pkg::payload_len(kind_q)}) phase_d = PH_CRC;
				end
				PH_CRC: begin
					outcome = 1'b1;
					ok      = (data_byte == crc_q);
				end
				default: ;
			endcase
			// one outcome per buffer; the end of a buffer without one is a failure
			if (outcome) begin
				phase_d = buffer_end ? PH_HUNT : PH_DONE;
			end else if (buffer_end) begin
				phase_d = PH_HUNT;
				outcome = (phase_q != PH_DONE);
			end
		end
	end

	// frame machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= 8'd0;
			cnt_q   <= 8'd0;
			crc_q   <= 8'd0;
			kind_q  <= crsf_pkg::KIND_RC;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			kind_q  <= kind_d;
		end
	end

	// payload store, written in byte order
	always_ff @(posedge clk) begin
		if (store_we && (cnt_q < 8'(crsf_pkg::PAYLOAD_BYTES)))
			store_q[cnt_q[crsf_pkg::STORE_IDX_W-1:0]] <= data_byte;
	end

	// outcome transaction toward the queue
	always_comb begin
		rec_push = outcome;
		rec.ok   = ok;
		rec.kind = kind_q;
		for (int i = 0; i < crsf_pkg::PAYLOAD_BYTES; i++) begin
			rec.payload[8*i +: 8] = store_q[i];
		end
	end

endmodule

FILE: sv/crsf_fifo.sv
// crsf_fifo: short queue of frame outcomes between front and back
// depends on crsf_pkg for the frame_rec_t entry type

module crsf_fifo #(
	parameter int DEPTH = crsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  crsf_pkg::frame_rec_t wr_data,
	output logic                 full,
	output logic                 rd_valid,
	input  logic                 rd_en,
	output crsf_pkg::frame_rec_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	crsf_pkg::frame_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wptr_q, rptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_wr, do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd) rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/crsf_back.sv
// crsf_back: unpacks a frame outcome into result slots and holds it in the output register
// depends on crsf_pkg

module crsf_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rec_valid,
	input  crsf_pkg::frame_rec_t               rec,
	output logic                               rec_pop,
	input  logic                               pop,
	output logic                               empty,
	output logic                               accepted,
	output logic [1:0]                         frame_kind,
	output logic [crsf_pkg::SLOT_BITS-1:0]     slots_0_3,
	output logic [crsf_pkg::SLOT_BITS-1:0]     slots_4_7,
	output logic [crsf_pkg::SLOT_BITS-1:0]     slots_8_11,
	output logic [crsf_pkg::SLOT_BITS-1:0]     slots_12_15
);

	localparam int CB = crsf_pkg::CHAN_BITS;
	localparam int SB = crsf_pkg::SLOT_BITS;

	logic [crsf_pkg::VALUE_BITS-1:0] vals;
	logic [crsf_pkg::VALUE_BITS-1:0] vals_q;
	logic [1:0]                      kind_q;
	logic                            ok_q;
	logic                            out_valid_q;
	logic [4:0]                      plen;

	// unpack: rc channels are an lsb-first bit stream, statistics are one byte each
	always_comb begin
		plen = crsf_pkg::payload_len(rec.kind);
		vals = '0;
		for (int i = 0; i < crsf_pkg::CHAN_COUNT; i++) begin
			if (rec.kind == crsf_pkg::KIND_RC)
				vals[CB*i +: CB] = rec.payload[CB*i +: CB];
			else if (5'(i) < plen)
				vals[CB*i +: CB] = {{(CB-8){1'b0}}, rec.payload[8*i +: 8]};
		end
		if (!rec.ok) vals = '0;
	end

	// output register loads when free or when its transaction is taken
	assign rec_pop = rec_valid && (!out_valid_q || pop);
	assign empty   = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_pop) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			ok_q   <= rec.ok;
			kind_q <= rec.ok ? rec.kind : crsf_pkg::KIND_RC;
			vals_q <= vals;
		end
	end

	assign accepted    = ok_q;
	assign frame_kind  = kind_q;
	assign slots_0_3   = vals_q[0*SB +: SB];
	assign slots_4_7   = vals_q[1*SB +: SB];
	assign slots_8_11  = vals_q[2*SB +: SB];
	assign slots_12_15 = vals_q[3*SB +: SB];

endmodule

FILE: sv/crsf_frame_parser.sv
// crsf_frame_parser: top level, front frame machine, outcome queue and result back end
// depends on crsf_pkg, crsf_front, crsf_fifo, crsf_back
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  bytes in  | push / full         | data_byte, buffer_end
//  results   | empty / pop         | accepted, frame_kind, slots_0_3 .. slots_12_15
//  config    | cfg_we              | cfg_index, cfg_data
//
// one byte is taken every cycle while full is low; the front frame machine and
// its crc update handle each taken byte as it arrives.
// a result passes from the byte that decides it through the outcome queue into
// the output register, and waits in the queue while that register is occupied.
// full rises only when the queue (QUEUE_DEPTH entries) and the output register
// are all holding results that have not been popped.
// reset clears the frame machine, queue and output register; the config
// registers return to their default values.

module crsf_frame_parser #(
	parameter int QUEUE_DEPTH = crsf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       data_byte,
	input  logic                             buffer_end,
	output logic                             empty,
	input  logic                             pop,
	output logic                             accepted,
	output logic [1:0]                       frame_kind,
	output logic [crsf_pkg::SLOT_BITS-1:0]   slots_0_3,
	output logic [crsf_pkg::SLOT_BITS-1:0]   slots_4_7,
	output logic [crsf_pkg::SLOT_BITS-1:0]   slots_8_11,
	output logic [crsf_pkg::SLOT_BITS-1:0]   slots_12_15,
	input  logic                             cfg_we,
	input  logic [crsf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_data
);

	logic                 q_full;
	logic                 rec_push;
	crsf_pkg::frame_rec_t rec_in;
	logic                 q_valid;
	logic                 q_pop;
	crsf_pkg::frame_rec_t rec_out;

	assign full = q_full;

	// byte-level front end
	crsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (q_full),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rec_push   (rec_push),
		.rec        (rec_in)
	);

	// outcome queue
	crsf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rec_push),
		.wr_data  (rec_in),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_en    (q_pop),
		.rd_data  (rec_out)
	);

	// result back end
	crsf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_valid   (q_valid),
		.rec         (rec_out),
		.rec_pop     (q_pop),
		.pop         (pop),
		.empty       (empty),
		.accepted    (accepted),
		.frame_kind  (frame_kind),
		.slots_0_3   (slots_0_3),
		.slots_4_7   (slots_4_7),
		.slots_8_11  (slots_8_11),
		.slots_12_15 (slots_12_15)
	);

	// front never writes an outcome into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) rec_push |-> !q_full)
		else $error("outcome written while queue full");

	// a decoded frame carries a supported kind
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && accepted) |-> (frame_kind != crsf_pkg::KIND_NONE))
		else $error("accepted result with unsupported kind");

	// a failure result is all zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !accepted) |-> (frame_kind == crsf_pkg::KIND_RC && slots_0_3 == '0
			&& slots_4_7 == '0 && slots_8_11 == '0 && slots_12_15 == '0))
		else $error("failure result with nonzero fields");

endmodule
